### rtl/core/imu2si_pkg.sv
// ----------------------------------------------------------------------------
// imu2si_pkg
// shared widths, codes and fixed-point constants of the imu raw to si converter
// ----------------------------------------------------------------------------
package imu2si_pkg;

  // smallest accelerometer shift, used at the widest (16g) range
  localparam int ACCEL_SHIFT_MIN = 11;

  // port widths
  localparam int CMD_W      = 2;
  localparam int RAW_W      = 16;
  localparam int WHOLE_W    = 9;
  localparam int MICRO_W    = 21;
  localparam int ACC_FS_W   = 5;
  localparam int GYR_FS_W   = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // sample kinds
  localparam logic [CMD_W-1:0] CMD_ACCEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GYRO  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEMP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNSUP = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_FS  = 1'b1;

  localparam logic [ACC_FS_W-1:0] ACC_FS_RESET = 5'd16;
  localparam logic [GYR_FS_W-1:0] GYR_FS_RESET = 11'd2000;

  // accelerometer: raw * standard gravity in micro units
  localparam logic signed [24:0] MICRO_G = 25'sd9806650;
  localparam int ACC_PROD_W = 40;
  localparam int CONV_W     = ACC_PROD_W - ACCEL_SHIFT_MIN;

  // gyro: raw * 31415920 / (sens * 180) reduced to raw * 1570796 / (sens * 9),
  // split as raw * a + floor(raw * b / d) with a reciprocal for the second term
  localparam int GYR_KNUM = 1570796;
  localparam int GYR_D0   = 1476;
  localparam int GYR_D1   = 2952;
  localparam int GYR_D2   = 5895;
  localparam int GYR_D3   = 11790;
  localparam int GYR_L0   = 11;
  localparam int GYR_L1   = 12;
  localparam int GYR_L2   = 13;
  localparam int GYR_L3   = 14;
  localparam int GYR_A_W  = 11;
  localparam int GYR_B_W  = 14;
  localparam int GYR_N_W  = 29;
  localparam int GYR_M_W  = 30;
  localparam int GYR_P_W  = GYR_N_W + GYR_M_W;
  localparam int GYR_Q_W  = 26;
  localparam int GYR_SH_W = 6;

  localparam logic [GYR_A_W-1:0] GYR_A [4] = '{
    GYR_A_W'(GYR_KNUM / GYR_D0), GYR_A_W'(GYR_KNUM / GYR_D1),
    GYR_A_W'(GYR_KNUM / GYR_D2), GYR_A_W'(GYR_KNUM / GYR_D3)};
  localparam logic [GYR_B_W-1:0] GYR_B [4] = '{
    GYR_B_W'(GYR_KNUM % GYR_D0), GYR_B_W'(GYR_KNUM % GYR_D1),
    GYR_B_W'(GYR_KNUM % GYR_D2), GYR_B_W'(GYR_KNUM % GYR_D3)};
  localparam logic [GYR_M_W-1:0] GYR_M [4] = '{
    GYR_M_W'(((64'd1 << (GYR_N_W + GYR_L0)) + GYR_D0 - 1) / GYR_D0),
    GYR_M_W'(((64'd1 << (GYR_N_W + GYR_L1)) + GYR_D1 - 1) / GYR_D1),
    GYR_M_W'(((64'd1 << (GYR_N_W + GYR_L2)) + GYR_D2 - 1) / GYR_D2),
    GYR_M_W'(((64'd1 << (GYR_N_W + GYR_L3)) + GYR_D3 - 1) / GYR_D3)};
  localparam logic [GYR_SH_W-1:0] GYR_SH [4] = '{
    GYR_SH_W'(GYR_N_W + GYR_L0), GYR_SH_W'(GYR_N_W + GYR_L1),
    GYR_SH_W'(GYR_N_W + GYR_L2), GYR_SH_W'(GYR_N_W + GYR_L3)};

  // split of a micro-unit magnitude into whole and millionths
  localparam int DV_W      = (CONV_W > GYR_Q_W) ? CONV_W : GYR_Q_W;
  localparam int FRAC_W    = 20;
  localparam int SPLIT_K   = DV_W + FRAC_W;
  localparam int SPLIT_M_W = DV_W + 1;
  localparam int WQ_W      = DV_W - 19;
  localparam logic [SPLIT_M_W-1:0] SPLIT_M =
    SPLIT_M_W'(((64'd1 << SPLIT_K) + 64'd999999) / 64'd1000000);
  localparam logic [FRAC_W-1:0] ONE_MILLION = 20'd1000000;
  localparam logic [FRAC_W-1:0] MICRO_MAX   = 20'd999999;
  localparam int WHOLE_POS_MAX = 255;
  localparam int WHOLE_NEG_MAX = 256;

  // temperature: |raw| / 326, then remainder * 500000 / 163
  localparam int TMP_K1      = 25;
  localparam int TMP_M1_W    = 17;
  localparam int TMP_PROD1_W = RAW_W + TMP_M1_W;
  localparam int TMP_Q_W     = 7;
  localparam int TMP_R_W     = 9;
  localparam int TMP_SC_W    = 19;
  localparam int TMP_N_W     = TMP_R_W + TMP_SC_W;
  localparam int TMP_K2      = 36;
  localparam int TMP_M2_W    = 29;
  localparam int TMP_PROD2_W = TMP_N_W + TMP_M2_W;
  localparam logic [TMP_R_W-1:0]  TMP_DIV1  = 9'd326;
  localparam logic [TMP_M1_W-1:0] TMP_M1    =
    TMP_M1_W'(((64'd1 << TMP_K1) + 64'd325) / 64'd326);
  localparam logic [TMP_SC_W-1:0] TMP_SCALE = 19'd500000;
  localparam logic [TMP_M2_W-1:0] TMP_M2    =
    TMP_M2_W'(((64'd1 << TMP_K2) + 64'd162) / 64'd163);
  localparam int TEMP_OFFSET = 25;

endpackage

### rtl/core/imu_raw_to_si_converter_top.sv
// ----------------------------------------------------------------------------
// imu_raw_to_si_converter_top
// converts tagged raw imu samples to whole units and millionths
// ----------------------------------------------------------------------------
// A request (start high while busy is low) carries one signed 16-bit raw
// sample and its kind: accelerometer, gyroscope, die temperature or an
// unsupported code. The block is a six-register pipeline with no stall, so
// busy stays low and one request may be issued every clock cycle. The result
// of a request is driven with out_strobe high for one cycle; results leave in
// request order. The receiver cannot hold results off and must take every
// strobe. Acceleration comes out in m/s2, angular rate in rad/s and
// temperature in degrees Celsius; the temperature fraction is never negative,
// the other fractions carry the sign of the value. An unsupported kind gives
// out_error with zero value fields. The two range registers are written
// through cfg_we / cfg_index / cfg_wdata and should only change while no
// request is in flight.
// ----------------------------------------------------------------------------
module imu_raw_to_si_converter_top
  import imu2si_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // request side
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic signed [RAW_W-1:0]    in_raw_sample,
  // result side
  output logic                       out_strobe,
  output logic signed [WHOLE_W-1:0]  out_whole_part,
  output logic signed [MICRO_W-1:0]  out_micro_part,
  output logic                       out_error,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  // --------------------------------------------------------------------------
  // range registers
  // --------------------------------------------------------------------------
  logic [ACC_FS_W-1:0] accel_fs_r;
  logic [GYR_FS_W-1:0] gyro_fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_fs_r <= ACC_FS_RESET;
      gyro_fs_r  <= GYR_FS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACCEL_FS: accel_fs_r <= cfg_wdata[ACC_FS_W-1:0];
        CFG_GYRO_FS:  gyro_fs_r  <= cfg_wdata[GYR_FS_W-1:0];
      endcase
    end
  end

  // the pipeline never stalls
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // stage 1: capture request, magnitude, range decode
  // --------------------------------------------------------------------------
  logic                    s1_v_r,    s1_v_nxt;
  logic [CMD_W-1:0]        s1_cmd_r,  s1_cmd_nxt;
  logic signed [RAW_W-1:0] s1_raw_r,  s1_raw_nxt;
  logic [RAW_W-1:0]        s1_mag_r,  s1_mag_nxt;
  logic [1:0]              s1_ash_r,  s1_ash_nxt;
  logic [1:0]              s1_gsel_r, s1_gsel_nxt;

  always_comb begin
    s1_v_nxt   = start && !busy;
    s1_cmd_nxt = in_cmd;
    s1_raw_nxt = in_raw_sample;
    // -32768 maps onto 32768 in the unsigned magnitude
    s1_mag_nxt = in_raw_sample[RAW_W-1] ? RAW_W'(-in_raw_sample) : RAW_W'(in_raw_sample);
    // extra shift above the minimum: 16g, 8g, 4g, 2g
    priority if (accel_fs_r > 5'd8) s1_ash_nxt = 2'd0;
    else if (accel_fs_r > 5'd4)     s1_ash_nxt = 2'd1;
    else if (accel_fs_r > 5'd2)     s1_ash_nxt = 2'd2;
    else                            s1_ash_nxt = 2'd3;
    // sensitivity select: 164, 328, 655, 1310 tenths
    priority if (gyro_fs_r > 11'd1000) s1_gsel_nxt = 2'd0;
    else if (gyro_fs_r > 11'd500)      s1_gsel_nxt = 2'd1;
    else if (gyro_fs_r > 11'd250)      s1_gsel_nxt = 2'd2;
    else                               s1_gsel_nxt = 2'd3;
  end

  // --------------------------------------------------------------------------
  // stage 2: first products (gravity scale, gyro a/b terms, temp reciprocal)
  // --------------------------------------------------------------------------
  logic                         s2_v_r,    s2_v_nxt;
  logic [CMD_W-1:0]             s2_cmd_r,  s2_cmd_nxt;
  logic                         s2_neg_r,  s2_neg_nxt;
  logic [1:0]                   s2_ash_r,  s2_ash_nxt;
  logic [1:0]                   s2_gsel_r, s2_gsel_nxt;
  logic [RAW_W-1:0]             s2_mag_r,  s2_mag_nxt;
  logic signed [ACC_PROD_W-1:0] s2_acc_r,  s2_acc_nxt;
  logic [GYR_N_W-1:0]           s2_gpb_r,  s2_gpb_nxt;
  logic [GYR_Q_W-1:0]           s2_gpa_r,  s2_gpa_nxt;
  logic [TMP_PROD1_W-1:0]       s2_tp_r,   s2_tp_nxt;

  logic [RAW_W+GYR_B_W-1:0]     gpb_full;
  logic [RAW_W+GYR_A_W-1:0]     gpa_full;

  always_comb begin
    s2_v_nxt    = s1_v_r;
    s2_cmd_nxt  = s1_cmd_r;
    s2_neg_nxt  = s1_raw_r[RAW_W-1];
    s2_ash_nxt  = s1_ash_r;
    s2_gsel_nxt = s1_gsel_r;
    s2_mag_nxt  = s1_mag_r;
    s2_acc_nxt  = s1_raw_r * MICRO_G;
    gpb_full    = s1_mag_r * GYR_B[s1_gsel_r];
    gpa_full    = s1_mag_r * GYR_A[s1_gsel_r];
    s2_gpb_nxt  = gpb_full[GYR_N_W-1:0];
    s2_gpa_nxt  = gpa_full[GYR_Q_W-1:0];
    s2_tp_nxt   = s1_mag_r * TMP_M1;
  end

  // --------------------------------------------------------------------------
  // stage 3: accel floor shift and magnitude, gyro reciprocal, temp remainder
  // --------------------------------------------------------------------------
  logic                   s3_v_r,    s3_v_nxt;
  logic [CMD_W-1:0]       s3_cmd_r,  s3_cmd_nxt;
  logic                   s3_neg_r,  s3_neg_nxt;
  logic [1:0]             s3_gsel_r, s3_gsel_nxt;
  logic [CONV_W-1:0]      s3_amag_r, s3_amag_nxt;
  logic [GYR_P_W-1:0]     s3_gp_r,   s3_gp_nxt;
  logic [GYR_Q_W-1:0]     s3_gpa_r,  s3_gpa_nxt;
  logic [TMP_Q_W-1:0]     s3_tq_r,   s3_tq_nxt;
  logic [TMP_R_W-1:0]     s3_tr_r,   s3_tr_nxt;

  logic signed [ACC_PROD_W-1:0] conv_full;
  logic [CONV_W-1:0]            conv_w;
  logic [RAW_W-1:0]             tq_mul;

  always_comb begin
    s3_v_nxt    = s2_v_r;
    s3_cmd_nxt  = s2_cmd_r;
    s3_neg_nxt  = s2_neg_r;
    s3_gsel_nxt = s2_gsel_r;
    // arithmetic shift rounds toward minus infinity
    conv_full   = s2_acc_r >>> (ACCEL_SHIFT_MIN + int'(s2_ash_r));
    conv_w      = conv_full[CONV_W-1:0];
    s3_amag_nxt = s2_neg_r ? -conv_w : conv_w;
    s3_gp_nxt   = s2_gpb_r * GYR_M[s2_gsel_r];
    s3_gpa_nxt  = s2_gpa_r;
    s3_tq_nxt   = TMP_Q_W'(s2_tp_r >> TMP_K1);
    tq_mul      = RAW_W'(s3_tq_nxt * TMP_DIV1);
    s3_tr_nxt   = TMP_R_W'(s2_mag_r - tq_mul);
  end

  // --------------------------------------------------------------------------
  // stage 4: gyro quotient, pick magnitude for the split, temp fraction scale
  // --------------------------------------------------------------------------
  logic                 s4_v_r,   s4_v_nxt;
  logic [CMD_W-1:0]     s4_cmd_r, s4_cmd_nxt;
  logic                 s4_neg_r, s4_neg_nxt;
  logic [DV_W-1:0]      s4_dv_r,  s4_dv_nxt;
  logic [TMP_Q_W-1:0]   s4_tq_r,  s4_tq_nxt;
  logic [TMP_N_W-1:0]   s4_tn_r,  s4_tn_nxt;

  logic [GYR_Q_W-1:0]   gyro_q;

  always_comb begin
    s4_v_nxt   = s3_v_r;
    s4_cmd_nxt = s3_cmd_r;
    s4_neg_nxt = s3_neg_r;
    gyro_q     = GYR_Q_W'(s3_gp_r >> GYR_SH[s3_gsel_r]) + s3_gpa_r;
    s4_dv_nxt  = (s3_cmd_r == CMD_ACCEL) ? DV_W'(s3_amag_r) : DV_W'(gyro_q);
    s4_tq_nxt  = s3_tq_r;
    s4_tn_nxt  = s3_tr_r * TMP_SCALE;
  end

  // --------------------------------------------------------------------------
  // stage 5: whole units by reciprocal of one million, temp millionths
  // --------------------------------------------------------------------------
  logic                 s5_v_r,   s5_v_nxt;
  logic [CMD_W-1:0]     s5_cmd_r, s5_cmd_nxt;
  logic                 s5_neg_r, s5_neg_nxt;
  logic [DV_W-1:0]      s5_dv_r,  s5_dv_nxt;
  logic [WQ_W-1:0]      s5_wq_r,  s5_wq_nxt;
  logic [TMP_Q_W-1:0]   s5_tq_r,  s5_tq_nxt;
  logic [FRAC_W-1:0]    s5_tmm_r, s5_tmm_nxt;

  logic [DV_W+SPLIT_M_W-1:0] split_full;
  logic [TMP_PROD2_W-1:0]    tmm_full;

  always_comb begin
    s5_v_nxt   = s4_v_r;
    s5_cmd_nxt = s4_cmd_r;
    s5_neg_nxt = s4_neg_r;
    s5_dv_nxt  = s4_dv_r;
    split_full = s4_dv_r * SPLIT_M;
    s5_wq_nxt  = WQ_W'(split_full >> SPLIT_K);
    s5_tq_nxt  = s4_tq_r;
    tmm_full   = s4_tn_r * TMP_M2;
    s5_tmm_nxt = FRAC_W'(tmm_full >> TMP_K2);
  end

  // --------------------------------------------------------------------------
  // stage 6: remainder, sign, saturation, temperature offset -> output register
  // --------------------------------------------------------------------------
  logic                       out_strobe_r, out_strobe_nxt;
  logic signed [WHOLE_W-1:0]  out_whole_r,  out_whole_nxt;
  logic signed [MICRO_W-1:0]  out_micro_r,  out_micro_nxt;
  logic                       out_error_r,  out_error_nxt;

  logic [WQ_W+FRAC_W-1:0]     wq_mul;
  logic [FRAC_W-1:0]          frac_mag;

  always_comb begin
    out_strobe_nxt = s5_v_r;
    out_whole_nxt  = '0;
    out_micro_nxt  = '0;
    out_error_nxt  = 1'b0;
    wq_mul         = s5_wq_r * ONE_MILLION;
    frac_mag       = FRAC_W'(s5_dv_r - DV_W'(wq_mul));
    unique case (s5_cmd_r)
      CMD_ACCEL, CMD_GYRO: begin
        // truncating split: both parts take the sign of the value
        priority if (!s5_neg_r && (32'(s5_wq_r) > WHOLE_POS_MAX)) begin
          out_whole_nxt = WHOLE_W'(WHOLE_POS_MAX);
          out_micro_nxt = MICRO_W'(MICRO_MAX);
        end else if (s5_neg_r && (32'(s5_wq_r) > WHOLE_NEG_MAX)) begin
          out_whole_nxt = WHOLE_W'(-WHOLE_NEG_MAX);
          out_micro_nxt = -MICRO_W'(MICRO_MAX);
        end else if (s5_neg_r) begin
          out_whole_nxt = -WHOLE_W'(s5_wq_r);
          out_micro_nxt = -MICRO_W'(frac_mag);
        end else begin
          out_whole_nxt = WHOLE_W'(s5_wq_r);
          out_micro_nxt = MICRO_W'(frac_mag);
        end
      end
      CMD_TEMP: begin
        // negative fraction is borrowed from the whole part
        priority if (!s5_neg_r) begin
          out_whole_nxt = WHOLE_W'(TEMP_OFFSET) + WHOLE_W'(s5_tq_r);
          out_micro_nxt = MICRO_W'(s5_tmm_r);
        end else if (s5_tmm_r != '0) begin
          out_whole_nxt = WHOLE_W'(TEMP_OFFSET - 1) - WHOLE_W'(s5_tq_r);
          out_micro_nxt = MICRO_W'(FRAC_W'(ONE_MILLION - s5_tmm_r));
        end else begin
          out_whole_nxt = WHOLE_W'(TEMP_OFFSET) - WHOLE_W'(s5_tq_r);
          out_micro_nxt = '0;
        end
      end
      CMD_UNSUP: begin
        out_error_nxt = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline registers: valid bits reset, payload runs free
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      s5_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_v_r       <= s1_v_nxt;
      s2_v_r       <= s2_v_nxt;
      s3_v_r       <= s3_v_nxt;
      s4_v_r       <= s4_v_nxt;
      s5_v_r       <= s5_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r  <= s1_cmd_nxt;
    s1_raw_r  <= s1_raw_nxt;
    s1_mag_r  <= s1_mag_nxt;
    s1_ash_r  <= s1_ash_nxt;
    s1_gsel_r <= s1_gsel_nxt;

    s2_cmd_r  <= s2_cmd_nxt;
    s2_neg_r  <= s2_neg_nxt;
    s2_ash_r  <= s2_ash_nxt;
    s2_gsel_r <= s2_gsel_nxt;
    s2_mag_r  <= s2_mag_nxt;
    s2_acc_r  <= s2_acc_nxt;
    s2_gpb_r  <= s2_gpb_nxt;
    s2_gpa_r  <= s2_gpa_nxt;
    s2_tp_r   <= s2_tp_nxt;

    s3_cmd_r  <= s3_cmd_nxt;
    s3_neg_r  <= s3_neg_nxt;
    s3_gsel_r <= s3_gsel_nxt;
    s3_amag_r <= s3_amag_nxt;
    s3_gp_r   <= s3_gp_nxt;
    s3_gpa_r  <= s3_gpa_nxt;
    s3_tq_r   <= s3_tq_nxt;
    s3_tr_r   <= s3_tr_nxt;

    s4_cmd_r  <= s4_cmd_nxt;
    s4_neg_r  <= s4_neg_nxt;
    s4_dv_r   <= s4_dv_nxt;
    s4_tq_r   <= s4_tq_nxt;
    s4_tn_r   <= s4_tn_nxt;

    s5_cmd_r  <= s5_cmd_nxt;
    s5_neg_r  <= s5_neg_nxt;
    s5_dv_r   <= s5_dv_nxt;
    s5_wq_r   <= s5_wq_nxt;
    s5_tq_r   <= s5_tq_nxt;
    s5_tmm_r  <= s5_tmm_nxt;

    out_whole_r <= out_whole_nxt;
    out_micro_r <= out_micro_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_whole_part = out_whole_r;
  assign out_micro_part = out_micro_r;
  assign out_error      = out_error_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // every request comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_strobe)
    else $error("request did not produce a result after six cycles");

  // unsupported kind leaves the value fields at zero
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_error) |-> (out_whole_part == '0 && out_micro_part == '0))
    else $error("error result with non-zero value");

  // fraction always below one whole unit
  a_micro_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_micro_part <= 21'sd999999 && out_micro_part >= -21'sd999999))
    else $error("fraction out of range");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the imu raw to si converter: a directed table at the
// reset ranges, then random requests over a sweep of range settings, every
// result checked against a typed-in value or a behavioural conversion model
module tb;
  import imu2si_pkg::*;

  // conversion constants; gravity and pi are in micro units
  localparam longint G_UMS2        = 64'sd9806650;   // standard gravity
  localparam longint PI_X10_MICRO  = 64'sd31415920;  // pi * 10 in millionths
  localparam longint USCALE        = 64'sd1000000;
  localparam longint TEMP_DIVISOR  = 64'sd32600;
  localparam longint TEMP_BASE     = 64'sd25;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 12;     // pipeline is six deep; wait after draining
  localparam int N_DIRECTED    = 20;
  localparam int N_PHASES      = 12;
  localparam int N_PLANNED     = 9;
  localparam int PHASE_ITEMS   = 88;

  typedef struct packed {
    logic signed [WHOLE_W-1:0] whole;
    logic signed [MICRO_W-1:0] micro;
    logic                      err;
  } si_value_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [RAW_W-1:0]   raw;
    logic                      pinned;   // expected value typed in below
    logic signed [WHOLE_W-1:0] whole;
    logic signed [MICRO_W-1:0] micro;
    logic                      err;
  } sample_row_t;

  typedef struct packed {
    logic [ACC_FS_W-1:0] acc_fs;
    logic [GYR_FS_W-1:0] gyr_fs;
  } range_pair_t;

  // directed requests at the reset ranges (16g, 2000 dps)
  sample_row_t sample_rows [N_DIRECTED] = '{
    '{CMD_ACCEL, 16'sd0,     1'b1, 9'sd0,   21'sd0, 1'b0},
    '{CMD_ACCEL, 16'sh7FFF,  1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_ACCEL, 16'sh8000,  1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_ACCEL, 16'sd1,     1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_ACCEL, -16'sd1,    1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_GYRO,  16'sd0,     1'b1, 9'sd0,   21'sd0, 1'b0},
    '{CMD_GYRO,  16'sh7FFF,  1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_GYRO,  16'sh8000,  1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_GYRO,  16'sd1,     1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_GYRO,  -16'sd1,    1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_TEMP,  16'sd0,     1'b1, 9'sd25,  21'sd0, 1'b0},
    '{CMD_TEMP,  16'sh7FFF,  1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_TEMP,  16'sh8000,  1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_TEMP,  -16'sd1,    1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_TEMP,  16'sd1,     1'b0, 9'sd0,   21'sd0, 1'b0},
    '{CMD_TEMP,  -16'sd8150, 1'b1, 9'sd0,   21'sd0, 1'b0},
    '{CMD_TEMP,  16'sd32600, 1'b1, 9'sd125, 21'sd0, 1'b0},
    '{CMD_UNSUP, 16'sd0,     1'b1, 9'sd0,   21'sd0, 1'b1},
    '{CMD_UNSUP, 16'sh7FFF,  1'b1, 9'sd0,   21'sd0, 1'b1},
    '{CMD_UNSUP, 16'sh8000,  1'b1, 9'sd0,   21'sd0, 1'b1}
  };

  // range settings for the first phases: every threshold on both sides,
  // the all-zero and all-ones extremes; later phases pick ranges at random
  range_pair_t range_plan [N_PLANNED] = '{
    '{5'd0,  11'd0},
    '{5'd31, 11'd2047},
    '{5'd1,  11'd250},
    '{5'd2,  11'd251},
    '{5'd3,  11'd500},
    '{5'd4,  11'd501},
    '{5'd5,  11'd1000},
    '{5'd8,  11'd1001},
    '{5'd9,  11'd2000}
  };

  logic signed [RAW_W-1:0] corner_raws [5] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1};

  // dut signals; the driven inputs are all known from time zero
  logic                      clk;
  logic                      rst_n         = 1'b0;
  logic                      start         = 1'b0;
  logic                      busy;
  logic [CMD_W-1:0]          in_cmd        = '0;
  logic signed [RAW_W-1:0]   in_raw_sample = '0;
  logic                      out_strobe;
  logic signed [WHOLE_W-1:0] out_whole_part;
  logic signed [MICRO_W-1:0] out_micro_part;
  logic                      out_error;
  logic                      cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index     = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata     = '0;

  // typed-in expectation travelling alongside the request
  logic      pinned_on    = 1'b0;
  si_value_t pinned_value = '0;

  // bench copy of the range registers and the results still owed
  logic [ACC_FS_W-1:0] acc_fs_model = ACC_FS_RESET;
  logic [GYR_FS_W-1:0] gyr_fs_model = GYR_FS_RESET;
  si_value_t           pending_si [$];
  int                  fail_count  = 0;
  int                  cycle_count = 0;
  logic                gaps_on     = 1'b1;

  imu_raw_to_si_converter_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_raw_sample  (in_raw_sample),
    .out_strobe     (out_strobe),
    .out_whole_part (out_whole_part),
    .out_micro_part (out_micro_part),
    .out_error      (out_error),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // behavioural conversion of one raw sample at the given ranges
  function automatic si_value_t convert_to_si(input logic [CMD_W-1:0] cmd,
                                              input logic signed [RAW_W-1:0] raw,
                                              input logic [ACC_FS_W-1:0] acc_fs,
                                              input logic [GYR_FS_W-1:0] gyr_fs);
    longint    sample;
    longint    conv;
    longint    whole;
    longint    micro;
    longint    scaled;
    longint    sens;
    int        shift;
    si_value_t res;
    sample  = raw;
    whole   = 0;
    micro   = 0;
    res.err = 1'b0;
    case (cmd)
      CMD_ACCEL, CMD_GYRO: begin
        if (cmd == CMD_ACCEL) begin
          // wider range, smaller shift
          if (acc_fs > 8)      shift = ACCEL_SHIFT_MIN;
          else if (acc_fs > 4) shift = ACCEL_SHIFT_MIN + 1;
          else if (acc_fs > 2) shift = ACCEL_SHIFT_MIN + 2;
          else                 shift = ACCEL_SHIFT_MIN + 3;
          // arithmetic shift rounds toward minus infinity
          conv = (sample * G_UMS2) >>> shift;
        end else begin
          if (gyr_fs > 1000)     sens = 164;
          else if (gyr_fs > 500) sens = 328;
          else if (gyr_fs > 250) sens = 655;
          else                   sens = 1310;
          conv = (sample * PI_X10_MICRO) / (sens * 180);
        end
        // truncating split, both parts carry the sign
        whole = conv / USCALE;
        micro = conv % USCALE;
      end
      CMD_TEMP: begin
        scaled = sample * 100;
        whole  = scaled / TEMP_DIVISOR + TEMP_BASE;
        micro  = ((scaled % TEMP_DIVISOR) * USCALE) / TEMP_DIVISOR;
        // fraction kept non-negative
        if (micro < 0) begin
          whole = whole - 1;
          micro = micro + USCALE;
        end else if (micro >= USCALE) begin
          whole = whole + 1;
          micro = micro - USCALE;
        end
      end
      default: res.err = 1'b1;
    endcase
    if (whole > 255) begin
      whole = 255;
      micro = 999999;
    end else if (whole < -256) begin
      whole = -256;
      micro = -999999;
    end
    res.whole = whole[WHOLE_W-1:0];
    res.micro = micro[MICRO_W-1:0];
    return res;
  endfunction

  // present one request and hold it until an edge with busy low takes it;
  // start is left high so back-to-back requests run without a gap
  task automatic issue_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [RAW_W-1:0] raw,
                               input logic pin,
                               input si_value_t pin_val);
    while (gaps_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_raw_sample <= raw;
    pinned_on     <= pin;
    pinned_value  <= pin_val;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    int                      row;
    int                      phase;
    int                      item;
    range_pair_t             ranges;
    logic [CMD_W-1:0]        cmd;
    logic signed [RAW_W-1:0] raw;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, typed rows carry their own expectation
    for (row = 0; row < N_DIRECTED; row++) begin
      issue_request(sample_rows[row].cmd, sample_rows[row].raw, sample_rows[row].pinned,
                    '{sample_rows[row].whole, sample_rows[row].micro, sample_rows[row].err});
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      // drain the pipeline before touching the ranges
      start <= 1'b0;
      while (pending_si.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);

      if (phase < N_PLANNED) begin
        ranges = range_plan[phase];
      end else begin
        ranges.acc_fs = ACC_FS_W'($urandom);
        ranges.gyr_fs = GYR_FS_W'($urandom);
      end
      // junk in the upper data bits of the accelerometer write must be dropped
      write_register(CFG_ACCEL_FS, {6'($urandom), ranges.acc_fs});
      write_register(CFG_GYRO_FS, ranges.gyr_fs);
      cfg_we <= 1'b0;

      // a long stretch with back-to-back requests only
      gaps_on = !(phase == 4 || phase == 5);

      for (item = 0; item < PHASE_ITEMS; item++) begin
        cmd = CMD_W'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) raw = corner_raws[$urandom_range(0, 4)];
        else                           raw = RAW_W'($urandom);
        issue_request(cmd, raw, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_si.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_si.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // scoreboard: expectations are queued on the edge that takes a request,
  // results are matched in order on the edge that ends their strobe cycle
  always @(posedge clk) begin
    si_value_t got;
    si_value_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_si.size());
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst_n) begin
      acc_fs_model = ACC_FS_RESET;
      gyr_fs_model = GYR_FS_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ACCEL_FS) acc_fs_model = cfg_wdata[ACC_FS_W-1:0];
        else                           gyr_fs_model = cfg_wdata[GYR_FS_W-1:0];
      end
      if (out_strobe) begin
        got = '{out_whole_part, out_micro_part, out_error};
        if (pending_si.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none, actual whole %0d micro %0d err %0b",
                   $time, got.whole, got.micro, got.err);
        end else begin
          want = pending_si.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t mismatch: expected whole %0d micro %0d err %0b,",
                     $time, want.whole, want.micro, want.err,
                     " actual whole %0d micro %0d err %0b",
                     got.whole, got.micro, got.err);
          end
        end
      end
      if (start && !busy) begin
        if (pinned_on) pending_si.push_back(pinned_value);
        else pending_si.push_back(convert_to_si(in_cmd, in_raw_sample, acc_fs_model,
                                                gyr_fs_model));
      end
    end
  end

endmodule
